[rtl/core/spq_pkg.sv]
// shared types and constants of the sorted priority queue
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VAL_W = 32;
    localparam int PRI_W = 16;
    localparam int OCC_W = 5;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_DEQUEUED = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic signed [PRI_W-1:0] pri;
    } entry_t;

    typedef struct packed {
        logic enq;
        logic deq;
    } cell_ctrl_t;

endpackage

`default_nettype wire

[rtl/core/spq_req_if.sv]
// request channel: opcode and the pair to insert
`timescale 1ns / 1ps
`default_nettype none

interface spq_req_if;
    logic                 valid;
    logic                 ready;
    logic                 opcode;
    logic signed [31:0]   item_value;
    logic signed [15:0]   item_priority;

    modport source (output valid, output opcode, output item_value, output item_priority,
                    input ready);
    modport sink (input valid, input opcode, input item_value, input item_priority,
                  output ready);
endinterface

`default_nettype wire

[rtl/core/spq_rsp_if.sv]
// response channel: status, removed pair and occupancy
`timescale 1ns / 1ps
`default_nettype none

interface spq_rsp_if;
    logic                 valid;
    logic                 ready;
    logic [1:0]           status;
    logic signed [31:0]   out_value;
    logic signed [15:0]   out_priority;
    logic [4:0]           occupancy;

    modport source (output valid, output status, output out_value, output out_priority,
                    output occupancy, input ready);
    modport sink (input valid, input status, input out_value, input out_priority,
                  input occupancy, output ready);
endinterface

`default_nettype wire

[rtl/core/sorted_priority_queue_top.sv]
// sorted priority queue built as a chain of compare-and-shift cells
// the result is registered and offered in the cycle after the request transaction
// throughput: one transaction per cycle while results are taken, every cell does one priority compare per cycle
// a new request is taken while the previous result waits, as long as the result register frees
// reset clears the entry count and the result valid; cell contents stay undefined
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue_top (
    input  wire         clk,
    input  wire         rst_n,
    spq_req_if.sink     req,
    spq_rsp_if.source   rsp
);

    localparam int DEPTH = spq_pkg::DEPTH;
    localparam int CNT_W = spq_pkg::CNT_W;
    localparam int OCC_W = spq_pkg::OCC_W;

    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      rsp_valid_reg;
    logic                      rsp_valid_next;
    spq_pkg::status_t          status_reg;
    spq_pkg::status_t          status_next;
    spq_pkg::entry_t           head_reg;
    spq_pkg::entry_t           head_next;
    logic [OCC_W-1:0]          occ_reg;
    logic [OCC_W-1:0]          occ_next;

    logic                      accept;
    logic                      full;
    logic                      empty;
    spq_pkg::cell_ctrl_t       ctrl;
    spq_pkg::entry_t           new_entry;
    spq_pkg::entry_t           cell_entry [DEPTH];
    logic                      cell_keep  [DEPTH];
    logic [CNT_W+OCC_W-1:0]    occ_wide;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);

    assign new_entry.value = req.item_value;
    assign new_entry.pri   = req.item_priority;

    assign ctrl.enq = accept && (req.opcode == spq_pkg::OP_ENQ) && !full;
    assign ctrl.deq = accept && (req.opcode == spq_pkg::OP_DEQ) && !empty;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic            occ_i;
            logic            left_keep_i;
            spq_pkg::entry_t left_i;
            spq_pkg::entry_t right_i;

            assign occ_i = (count_reg > CNT_W'(i));

            if (i == 0)
            begin : g_first
                assign left_keep_i = 1'b1;
                assign left_i      = new_entry;
            end
            else
            begin : g_inner
                assign left_keep_i = cell_keep[i-1];
                assign left_i      = cell_entry[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign right_i = '0;
            end
            else
            begin : g_mid
                assign right_i = cell_entry[i+1];
            end

            spq_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .new_entry   (new_entry),
                .occupied    (occ_i),
                .left_keep   (left_keep_i),
                .left_entry  (left_i),
                .right_entry (right_i),
                .keep        (cell_keep[i]),
                .entry       (cell_entry[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.enq)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.deq)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign occ_wide = {{OCC_W{1'b0}}, count_next};

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        status_next    = status_reg;
        head_next      = head_reg;
        occ_next       = occ_reg;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
            occ_next       = occ_wide[OCC_W-1:0];
            head_next      = '0;
            if (req.opcode == spq_pkg::OP_ENQ)
            begin
                status_next = full ? spq_pkg::ST_FULL : spq_pkg::ST_INSERTED;
            end
            else if (empty)
            begin
                status_next = spq_pkg::ST_EMPTY;
            end
            else
            begin
                status_next = spq_pkg::ST_DEQUEUED;
                head_next   = cell_entry[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        head_reg   <= head_next;
        occ_reg    <= occ_next;
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.out_value    = head_reg.value;
    assign rsp.out_priority = head_reg.pri;
    assign rsp.occupancy    = occ_reg;

endmodule

`default_nettype wire

[rtl/core/spq_cell.sv]
// one slot of the sorted shift chain
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
    input  wire                       clk,
    input  wire spq_pkg::cell_ctrl_t  ctrl,
    input  wire spq_pkg::entry_t      new_entry,
    input  wire                       occupied,
    input  wire                       left_keep,
    input  wire spq_pkg::entry_t      left_entry,
    input  wire spq_pkg::entry_t      right_entry,
    output logic                      keep,
    output spq_pkg::entry_t           entry
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;

    // entry stays in place on insert when it sorts at or before the new one
    assign keep  = occupied && (entry_reg.pri <= new_entry.pri);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.enq)
        begin
            if (!keep)
            begin
                if (left_keep)
                begin
                    entry_next = new_entry;
                end
                else
                begin
                    entry_next = left_entry;
                end
            end
        end
        else if (ctrl.deq)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire
